/* rtl/gpiq_pkg.sv */
package gpiq_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_THRESHOLD  = 2'd2;

    // Register reset values
    localparam logic [14:0] DEAD_ZONE_RST       = 15'd7849;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;
    localparam logic [14:0] TILT_THRESHOLD_RST  = 15'd3276;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Number of stick direction bits (two sticks, four directions each)
    localparam int unsigned NUM_DIRS = 8;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [15:0]         raw_buttons;
        logic [3:0]          dpad;
        logic [NUM_DIRS-1:0] stick_dirs;
        logic [31:0]         now_ms;
    } t_front_item;

endpackage

/* rtl/gpiq_front.sv */
module gpiq_front (
    input  logic [15:0]         i_raw_buttons,
    input  logic signed [15:0]  i_left_x,
    input  logic signed [15:0]  i_left_y,
    input  logic signed [15:0]  i_right_x,
    input  logic signed [15:0]  i_right_y,
    input  logic [31:0]         i_now_ms,
    input  logic [14:0]         i_dead_zone,
    input  logic [14:0]         i_tilt_threshold,
    output gpiq_pkg::t_front_item o_item
);
    import gpiq_pkg::*;

    // Magnitude of a 16-bit signed axis; -32768 maps to 32768
    function automatic logic [16:0] axis_mag(input logic signed [15:0] v);
        logic signed [16:0] ve;
        ve = {v[15], v};
        return ve[16] ? 17'(-ve) : 17'(ve);
    endfunction

    // Four direction bits: 0 up, 1 down, 2 left, 3 right
    function automatic logic [3:0] classify(input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic [14:0] thr);
        logic [16:0] ax;
        logic [16:0] ay;
        logic [16:0] m;
        logic [3:0]  d;
        ax = axis_mag(x);
        ay = axis_mag(y);
        m  = (ax > ay) ? ax : ay;
        d  = 4'b0000;
        if (m > {2'b00, thr}) begin
            if (ay > ax) begin
                d = (y > 16'sd0) ? 4'b0001 : 4'b0010;
            end else if (ax > ay) begin
                d = (x > 16'sd0) ? 4'b1000 : 4'b0100;
            end
        end
        return d;
    endfunction

    logic signed [16:0] dz_pos;
    logic signed [16:0] dz_neg;
    logic signed [16:0] lx_e;
    logic signed [16:0] ly_e;
    logic [3:0]         dpad;

    // Dead zone d-pad from the left stick
    assign dz_pos = {2'b00, i_dead_zone};
    assign dz_neg = -dz_pos;
    assign lx_e   = {i_left_x[15], i_left_x};
    assign ly_e   = {i_left_y[15], i_left_y};

    always_comb begin
        dpad = 4'b0000;
        if (ly_e >= dz_pos) begin
            dpad[0] = 1'b1;
        end else if (ly_e <= dz_neg) begin
            dpad[1] = 1'b1;
        end
        if (lx_e <= dz_neg) begin
            dpad[2] = 1'b1;
        end else if (lx_e >= dz_pos) begin
            dpad[3] = 1'b1;
        end
    end

    // Pack the classified sample
    always_comb begin
        o_item.raw_buttons = i_raw_buttons;
        o_item.dpad        = dpad;
        o_item.stick_dirs  = {classify(i_right_x, i_right_y, i_tilt_threshold),
                              classify(i_left_x, i_left_y, i_tilt_threshold)};
        o_item.now_ms      = i_now_ms;
    end

endmodule

/* rtl/gpiq_queue.sv */
module gpiq_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gpiq_pkg::t_front_item i_item,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output gpiq_pkg::t_front_item o_item
);
    import gpiq_pkg::*;

    t_front_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/gpiq_back.sv */
module gpiq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    input  gpiq_pkg::t_front_item i_item,
    output logic                 o_pop,
    input  logic [15:0]          i_repeat_interval,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_held_buttons,
    output logic [15:0]          o_pressed_edges,
    output logic [15:0]          o_released_edges,
    output logic [15:0]          o_repeat_buttons,
    output logic [7:0]           o_stick_held,
    output logic [7:0]           o_stick_pressed,
    output logic [7:0]           o_stick_released,
    output logic [7:0]           o_stick_repeat
);
    import gpiq_pkg::*;

    // History state
    logic [15:0]         r_last_merged;
    logic [15:0]         r_btn_time;
    logic [NUM_DIRS-1:0] r_last_sticks;
    logic [31:0]         r_dir_time [NUM_DIRS];

    // Output register
    logic                r_out_valid;
    logic [15:0]         r_held, r_pressed, r_released, r_rep;
    logic [NUM_DIRS-1:0] r_sh, r_sp, r_sr, r_srep;

    logic [15:0]         merged;
    logic [15:0]         dt16;
    logic                btn_fire;
    logic [NUM_DIRS-1:0] dir_fire;
    logic [31:0]         dir_dt [NUM_DIRS];

    // Take the next sample when the output slot is free or being drained
    assign o_pop = i_avail && (!r_out_valid || i_ready);

    // Button edges and repeat
    assign merged   = i_item.raw_buttons | {12'd0, i_item.dpad};
    assign dt16     = i_item.now_ms[15:0] - r_btn_time;
    assign btn_fire = (merged != 16'd0) && (dt16 > i_repeat_interval);

    // Per-direction repeat timers
    always_comb begin
        for (int i = 0; i < NUM_DIRS; i++) begin
            dir_dt[i]   = i_item.now_ms - r_dir_time[i];
            dir_fire[i] = i_item.stick_dirs[i] && (dir_dt[i] > {16'd0, i_repeat_interval});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_merged <= '0;
            r_btn_time    <= '0;
            r_last_sticks <= '0;
            for (int i = 0; i < NUM_DIRS; i++) begin
                r_dir_time[i] <= '0;
            end
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_last_merged <= merged;
                r_last_sticks <= i_item.stick_dirs;
                if (btn_fire) begin
                    r_btn_time <= i_item.now_ms[15:0];
                end
                for (int i = 0; i < NUM_DIRS; i++) begin
                    if (dir_fire[i]) begin
                        r_dir_time[i] <= i_item.now_ms;
                    end
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_held     <= merged;
            r_pressed  <= i_item.raw_buttons & ~r_last_merged;
            r_released <= ~i_item.raw_buttons & r_last_merged;
            r_rep      <= btn_fire ? merged : 16'd0;
            r_sh       <= i_item.stick_dirs;
            r_sp       <= i_item.stick_dirs & ~r_last_sticks;
            r_sr       <= ~i_item.stick_dirs & r_last_sticks;
            r_srep     <= dir_fire;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_held_buttons   = r_held;
    assign o_pressed_edges  = r_pressed;
    assign o_released_edges = r_released;
    assign o_repeat_buttons = r_rep;
    assign o_stick_held     = r_sh;
    assign o_stick_pressed  = r_sp;
    assign o_stick_released = r_sr;
    assign o_stick_repeat   = r_srep;

`ifndef SYNTHESIS
    // Stick history follows the sample just moved to the output
    a_stick_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_last_sticks == r_sh))
        else $error("stick history does not match last result");

    // Merged history follows the sample just moved to the output
    a_button_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_last_merged == r_held))
        else $error("button history does not match last result");

    // A stick repeat only fires on a held direction
    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_srep & ~r_sh) == '0))
        else $error("stick repeat on a direction not held");

    // Button repeat is either silent or the whole merged word
    a_button_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_rep == 16'd0) || (r_rep == r_held)))
        else $error("button repeat differs from merged word");

    // At most one direction per stick
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($onehot0(r_sh[3:0]) && $onehot0(r_sh[7:4])))
        else $error("stick holds more than one direction");
`endif

endmodule

/* rtl/gamepad_input_qualifier.sv */
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// sample   | i_valid / o_ready   | i_raw_buttons, i_left_x/y, i_right_x/y, i_now_ms
// result   | o_valid / i_ready   | o_held_buttons .. o_stick_repeat
// config   | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained while i_ready holds.
// The front stage classifies in the transfer cycle and writes a 4-entry queue;
// the back stage applies edge and repeat history and loads the output register.
// Output stalls back up through the queue; o_ready drops only when it is full.
// Synchronous active-low reset clears history, queue and output valid, and
// restores register defaults.
module gamepad_input_qualifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [gpiq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gpiq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // sample channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [15:0]                    i_raw_buttons,
    input  logic signed [15:0]             i_left_x,
    input  logic signed [15:0]             i_left_y,
    input  logic signed [15:0]             i_right_x,
    input  logic signed [15:0]             i_right_y,
    input  logic [31:0]                    i_now_ms,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [15:0]                    o_held_buttons,
    output logic [15:0]                    o_pressed_edges,
    output logic [15:0]                    o_released_edges,
    output logic [15:0]                    o_repeat_buttons,
    output logic [7:0]                     o_stick_held,
    output logic [7:0]                     o_stick_pressed,
    output logic [7:0]                     o_stick_released,
    output logic [7:0]                     o_stick_repeat
);
    import gpiq_pkg::*;

    logic [14:0] r_dead_zone;
    logic [15:0] r_repeat_interval;
    logic [14:0] r_tilt_threshold;

    t_front_item front_item;
    t_front_item queue_item;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone       <= DEAD_ZONE_RST;
            r_repeat_interval <= REPEAT_INTERVAL_RST;
            r_tilt_threshold  <= TILT_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEAD_ZONE:       r_dead_zone       <= i_cfg_data[14:0];
                CFG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data;
                CFG_TILT_THRESHOLD:  r_tilt_threshold  <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify the incoming sample
    gpiq_front u_front (
        .i_raw_buttons    (i_raw_buttons),
        .i_left_x         (i_left_x),
        .i_left_y         (i_left_y),
        .i_right_x        (i_right_x),
        .i_right_y        (i_right_y),
        .i_now_ms         (i_now_ms),
        .i_dead_zone      (r_dead_zone),
        .i_tilt_threshold (r_tilt_threshold),
        .o_item           (front_item)
    );

    assign o_ready = !q_full;
    assign q_push  = i_valid && !q_full;

    // Queue between front and back
    gpiq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (queue_item)
    );

    // Back: history, edges, repeats and output register
    gpiq_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_avail           (!q_empty),
        .i_item            (queue_item),
        .o_pop             (q_pop),
        .i_repeat_interval (r_repeat_interval),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_held_buttons    (o_held_buttons),
        .o_pressed_edges   (o_pressed_edges),
        .o_released_edges  (o_released_edges),
        .o_repeat_buttons  (o_repeat_buttons),
        .o_stick_held      (o_stick_held),
        .o_stick_pressed   (o_stick_pressed),
        .o_stick_released  (o_stick_released),
        .o_stick_repeat    (o_stick_repeat)
    );

endmodule
